FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ussptb_pkg.sv
// ---------------------------------------------------------------------------
// ussptb_pkg
// Types and constants of the USS PPO1 parameter telegram builder.
// ---------------------------------------------------------------------------
`default_nettype none

package ussptb_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int IN_DATA_W   = 64;

    localparam logic [7:0] FRAME_STX = 8'h02;
    localparam logic [7:0] FRAME_LGE = 8'd14;

    // PKE task IDs (high byte of PKE)
    localparam logic [7:0] TASK_RD_SCALAR = 8'h10;
    localparam logic [7:0] TASK_RD_ARRAY  = 8'h60;
    localparam logic [7:0] TASK_WR_SCALAR = 8'h20;
    localparam logic [7:0] TASK_WR_ARRAY  = 8'h80;

    localparam logic [7:0] IND_RAW_LIMIT = 8'd64;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    // byte 0 (STX) in the lowest bits
    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_frame_slot;

endpackage

`default_nettype wire

FILE: hdl/ussptb_build.sv
// ---------------------------------------------------------------------------
// ussptb_build
// Assembles a complete telegram from one request and holds it until the
// serialiser takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module ussptb_build
    import ussptb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_opcode              i_opcode,
    input  wire logic [7:0]           i_slave_address,
    input  wire logic [10:0]          i_param_number,
    input  wire logic [1:0]           i_set_num,
    input  wire logic [7:0]           i_array_index,
    input  wire logic [31:0]          i_write_value,
    input  wire logic                 i_take,
    output t_frame_slot               o_slot
);

    logic        r_valid;
    t_frame      r_frame;
    t_frame      n_frame;
    logic [7:0]  task_id;
    logic [15:0] pke;
    logic [15:0] ind;
    logic [31:0] pwe;
    logic [7:0]  idx_m1;
    logic [7:0]  bcc;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        if (i_array_index != 8'd0) begin
            task_id = (i_opcode == OP_WRITE) ? TASK_WR_ARRAY : TASK_RD_ARRAY;
        end else begin
            task_id = (i_opcode == OP_WRITE) ? TASK_WR_SCALAR : TASK_RD_SCALAR;
        end
        pke    = {task_id, 8'h00} | {5'd0, i_param_number};
        idx_m1 = (i_array_index != 8'd0) ? (i_array_index - 8'd1) : 8'd0;
        if (i_array_index > IND_RAW_LIMIT) begin
            ind = {8'd0, i_array_index};
        end else begin
            ind = {8'd0, idx_m1[5:0], i_set_num};
        end
        pwe = (i_opcode == OP_WRITE) ? i_write_value : 32'd0;

        n_frame      = '0;
        n_frame[0]   = FRAME_STX;
        n_frame[1]   = FRAME_LGE;
        n_frame[2]   = i_slave_address;
        n_frame[3]   = pke[15:8];
        n_frame[4]   = pke[7:0];
        n_frame[5]   = ind[15:8];
        n_frame[6]   = ind[7:0];
        n_frame[7]   = pwe[31:24];
        n_frame[8]   = pwe[23:16];
        n_frame[9]   = pwe[15:8];
        n_frame[10]  = pwe[7:0];
        // STW and HSW stay zero
        bcc = 8'd0;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            bcc = bcc ^ n_frame[i];
        end
        n_frame[FRAME_BYTES-1] = bcc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_frame <= n_frame;
        end
    end

    assign o_slot = '{valid: r_valid, frame: r_frame};

endmodule

`default_nettype wire

FILE: hdl/ussptb_serial.sv
// ---------------------------------------------------------------------------
// ussptb_serial
// Shifts a held telegram out one byte per word, marking the checksum byte.
// ---------------------------------------------------------------------------
`default_nettype none

module ussptb_serial
    import ussptb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_frame_slot i_slot,
    output logic             o_take,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_data,
    output logic             o_last
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_frame           r_shift;
    logic             fire;

    assign fire    = r_busy && i_ready;
    assign o_last  = (r_cnt == CNT_W'(FRAME_BYTES - 1));
    assign o_take  = i_slot.valid && (!r_busy || (fire && o_last));
    assign o_valid = r_busy;
    assign o_data  = r_shift[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (fire) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_shift <= i_slot.frame;
        end else if (fire) begin
            r_shift <= {8'h00, r_shift[FRAME_BYTES-1:1]};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/uss_param_telegram_builder.sv
// ---------------------------------------------------------------------------
// uss_param_telegram_builder
// USS PPO1 parameter telegram builder: one request in, sixteen bytes out.
// ---------------------------------------------------------------------------
// Slave side takes one read or write request per word: tuser carries the
// opcode, tdata the address, parameter number, set, index and value.
// Master side gives the telegram one byte per word, STX first; tlast marks
// the sixteenth byte, the BCC checksum.
// A request passes through the holding register and then the output shifter
// before its first byte appears; the byte-wide output limits the request rate,
// and the next telegram follows the previous BCC byte with no gap.
// A built telegram waits in a holding register, so a new request is taken
// while the previous telegram is still being sent.
// When the receiver stalls, the current byte holds and, once the holding
// register is full, o_s_tready drops.
// Reset empties both the holding register and the output shifter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module uss_param_telegram_builder
    import ussptb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // [7:0] slave_address, [18:8] param_number, [20:19] set_num,
    // [28:21] array_index, [60:29] write_value, [63:61] zero
    input  wire logic [IN_DATA_W-1:0] i_s_tdata,
    // [0] opcode
    input  wire logic                 i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // [7:0] frame_byte
    output logic [7:0]                o_m_tdata,
    output logic                      o_m_tlast
);

    t_frame_slot slot;
    logic        take;

    ussptb_build u_build (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_tvalid),
        .o_ready         (o_s_tready),
        .i_opcode        (t_opcode'(i_s_tuser)),
        .i_slave_address (i_s_tdata[7:0]),
        .i_param_number  (i_s_tdata[18:8]),
        .i_set_num       (i_s_tdata[20:19]),
        .i_array_index   (i_s_tdata[28:21]),
        .i_write_value   (i_s_tdata[60:29]),
        .i_take          (take),
        .o_slot          (slot)
    );

    ussptb_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (slot),
        .o_take  (take),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

    `ASSERT_NEXT(a_in_held, i_s_tvalid && o_s_tready, slot.valid, "accepted request not held")
    `ASSERT_NEXT(a_frame_runs, o_m_tvalid && i_m_tready && !o_m_tlast,
                 o_m_tvalid, "telegram cut short")
    `ASSERT_NEXT(a_next_stx, o_m_tvalid && i_m_tready && o_m_tlast && slot.valid,
                 o_m_tvalid && o_m_tdata == FRAME_STX, "queued telegram not started with STX")
    `ASSERT_IMP(a_take_ok, take, slot.valid, "serialiser took an empty slot")

endmodule

`default_nettype wire
